// File: rtl/core/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/bdcq_pkg.sv
package bdcq_pkg;

  localparam int unsigned NUM_BUTTONS = 24;
  localparam int unsigned QUEUE_DEPTH = 8;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned BTN_W     = 5;
  localparam int unsigned LEVEL_W   = 4;
  localparam int unsigned BTN_IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int unsigned QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(35);
  localparam logic [CFG_W-1:0] COOLDOWN_RESET = CFG_W'(800);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 1'b1;

  // opcodes
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } bdcq_state_e;

  typedef struct packed {
    logic load;       // capture a new transaction
    logic scan_step;  // evaluate one button
    logic pop_step;   // take the oldest queue entry
    logic load_out;   // move the result into the output register
  } bdcq_cmd_t;

  typedef struct packed {
    logic op_pop;
    logic last_btn;
  } bdcq_sts_t;

endpackage

// File: rtl/core/bdcq_ctrl.sv
module bdcq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  bdcq_pkg::bdcq_sts_t sts_i,
  output bdcq_pkg::bdcq_cmd_t cmd_o
);
  import bdcq_pkg::*;

  bdcq_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.op_pop || sts_i.last_btn) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.pop_step  = sts_i.op_pop;
        cmd_o.scan_step = !sts_i.op_pop;
      end
      ST_DONE: begin
        cmd_o.load_out = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/bdcq_datapath.sv
module bdcq_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bdcq_pkg::bdcq_cmd_t                 cmd_i,
  output bdcq_pkg::bdcq_sts_t                 sts_o,
  input  logic                                opcode_i,
  input  logic [bdcq_pkg::TIME_W-1:0]         now_ms_i,
  input  logic [bdcq_pkg::NUM_BUTTONS-1:0]    raw_pressed_i,
  input  logic                                cfg_we_i,
  input  logic [bdcq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bdcq_pkg::CFG_W-1:0]          cfg_wdata_i,
  output logic [bdcq_pkg::NUM_BUTTONS-1:0]    triggered_mask_o,
  output logic [bdcq_pkg::NUM_BUTTONS-1:0]    dropped_mask_o,
  output logic [bdcq_pkg::BTN_W-1:0]          popped_button_o,
  output logic                                popped_valid_o,
  output logic [bdcq_pkg::LEVEL_W-1:0]        queue_level_o
);
  import bdcq_pkg::*;

  // configuration
  logic [CFG_W-1:0] deb_q, cool_q;

  // captured transaction
  logic                   op_q;
  logic [TIME_W-1:0]      now_q;
  logic [NUM_BUTTONS-1:0] raw_q;

  // debounce state
  logic [NUM_BUTTONS-1:0] last_raw_q, last_raw_d;
  logic [NUM_BUTTONS-1:0] stable_q, stable_d;
  logic [TIME_W-1:0]      rct_q [NUM_BUTTONS];
  logic [TIME_W-1:0]      trg_q [NUM_BUTTONS];

  // event queue
  logic [BTN_W-1:0]  queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [QCNT_W-1:0] count_q, count_d;

  // walk and result accumulation
  logic [BTN_IDX_W-1:0]   btn_q, btn_d;
  logic [NUM_BUTTONS-1:0] trig_q, trig_d, drop_q, drop_d;
  logic [BTN_W-1:0]       pbtn_q, pbtn_d;
  logic                   pvalid_q, pvalid_d;

  // output register
  logic [NUM_BUTTONS-1:0] out_trig_q, out_drop_q;
  logic [BTN_W-1:0]       out_pbtn_q;
  logic                   out_pvalid_q;
  logic [LEVEL_W-1:0]     out_level_q;

  // per-button evaluation
  logic              level, prev, stab, changed, held, flip, cool_ok, fire, full, push;
  logic [TIME_W-1:0] rct_cur;

  assign level   = raw_q[btn_q];
  assign prev    = last_raw_q[btn_q];
  assign stab    = stable_q[btn_q];
  assign changed = level != prev;
  assign rct_cur = changed ? now_q : rct_q[btn_q];
  assign held    = (now_q - rct_cur) >= {{(TIME_W-CFG_W){1'b0}}, deb_q};
  assign flip    = held && (level != stab);
  assign cool_ok = (now_q - trg_q[btn_q]) >= {{(TIME_W-CFG_W){1'b0}}, cool_q};
  assign fire    = cmd_i.scan_step && flip && level && cool_ok;
  assign full    = count_q == QCNT_W'(QUEUE_DEPTH);
  assign push    = fire && !full;

  assign sts_o.op_pop   = op_q == OP_POP;
  assign sts_o.last_btn = btn_q == BTN_IDX_W'(NUM_BUTTONS - 1);

  always_comb begin
    last_raw_d = last_raw_q;
    stable_d   = stable_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    btn_d      = btn_q;
    trig_d     = trig_q;
    drop_d     = drop_q;
    pbtn_d     = pbtn_q;
    pvalid_d   = pvalid_q;

    if (cmd_i.load) begin
      btn_d    = '0;
      trig_d   = '0;
      drop_d   = '0;
      pbtn_d   = '0;
      pvalid_d = 1'b0;
    end

    if (cmd_i.scan_step) begin
      btn_d = btn_q + 1'b1;
      if (changed) last_raw_d[btn_q] = level;
      if (flip) stable_d[btn_q] = level;
      if (push) begin
        trig_d[btn_q] = 1'b1;
        tail_d  = (tail_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
        count_d = count_q + 1'b1;
      end else if (fire) begin
        drop_d[btn_q] = 1'b1;
      end
    end

    if (cmd_i.pop_step && count_q != '0) begin
      pbtn_d   = queue_q[head_q];
      pvalid_d = 1'b1;
      head_d   = (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q      <= DEBOUNCE_RESET;
      cool_q     <= COOLDOWN_RESET;
      last_raw_q <= '0;
      stable_q   <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      btn_q      <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        rct_q[i] <= '0;
        trg_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEBOUNCE: deb_q  <= cfg_wdata_i;
          CFG_COOLDOWN: cool_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      btn_q      <= btn_d;
      if (cmd_i.scan_step && changed) rct_q[btn_q] <= now_q;
      if (fire) trg_q[btn_q] <= now_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      now_q <= now_ms_i;
      raw_q <= raw_pressed_i;
    end
    if (push) queue_q[tail_q] <= BTN_W'(btn_q);
    trig_q   <= trig_d;
    drop_q   <= drop_d;
    pbtn_q   <= pbtn_d;
    pvalid_q <= pvalid_d;
    if (cmd_i.load_out) begin
      out_trig_q   <= trig_q;
      out_drop_q   <= drop_q;
      out_pbtn_q   <= pbtn_q;
      out_pvalid_q <= pvalid_q;
      out_level_q  <= LEVEL_W'(count_q);
    end
  end

  assign triggered_mask_o = out_trig_q;
  assign dropped_mask_o   = out_drop_q;
  assign popped_button_o  = out_pbtn_q;
  assign popped_valid_o   = out_pvalid_q;
  assign queue_level_o    = out_level_q;

endmodule

// File: rtl/core/button_debounce_cooldown_queue_core.sv
// Debouncer for 24 active-high buttons with an 8-entry event queue. A scan
// transaction (opcode 0) walks the buttons one per clock through a single
// compare unit: it is accepted, evaluates each of the 24 buttons in turn,
// then loads the output register once any earlier result has been taken. A
// pop transaction (opcode 1) is accepted, takes the oldest queue entry, then
// loads the output register in the same way. One transaction is worked on
// at a time; the result sits in an output register, so the next transaction
// is accepted while an earlier result still waits for out_ready_i.
// Configuration writes (index 0 debounce, index 1 cooldown, in ms) take
// effect at once and are meant for when the block is idle.
module button_debounce_cooldown_queue_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [bdcq_pkg::TIME_W-1:0]      now_ms_i,
  input  logic [bdcq_pkg::NUM_BUTTONS-1:0] raw_pressed_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bdcq_pkg::NUM_BUTTONS-1:0] triggered_mask_o,
  output logic [bdcq_pkg::NUM_BUTTONS-1:0] dropped_mask_o,
  output logic [bdcq_pkg::BTN_W-1:0]       popped_button_o,
  output logic                             popped_valid_o,
  output logic [bdcq_pkg::LEVEL_W-1:0]     queue_level_o,
  input  logic                             cfg_we_i,
  input  logic [bdcq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bdcq_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import bdcq_pkg::*;

  `include "assert_macros.svh"

  bdcq_cmd_t cmd;
  bdcq_sts_t sts;

  bdcq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bdcq_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (opcode_i),
    .now_ms_i         (now_ms_i),
    .raw_pressed_i    (raw_pressed_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .triggered_mask_o (triggered_mask_o),
    .dropped_mask_o   (dropped_mask_o),
    .popped_button_o  (popped_button_o),
    .popped_valid_o   (popped_valid_o),
    .queue_level_o    (queue_level_o)
  );

  `ASSERT_IMP(a_level_bound, out_valid_o, queue_level_o <= LEVEL_W'(QUEUE_DEPTH))
  `ASSERT_IMP(a_trig_drop_disjoint, out_valid_o, (triggered_mask_o & dropped_mask_o) == '0)
  `ASSERT_IMP(a_pop_no_masks, out_valid_o && popped_valid_o,
              triggered_mask_o == '0 && dropped_mask_o == '0)
  `ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.scan_step, cmd.pop_step, cmd.load_out}))

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdcq_pkg::*;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] trig;
    logic [NUM_BUTTONS-1:0] drop;
    logic [BTN_W-1:0]       btn;
    logic                   pvalid;
    logic [LEVEL_W-1:0]     level;
  } outcome_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   opcode_i = OP_SCAN;
  logic [TIME_W-1:0]      now_ms_i = '0;
  logic [NUM_BUTTONS-1:0] raw_pressed_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [NUM_BUTTONS-1:0] triggered_mask_o;
  logic [NUM_BUTTONS-1:0] dropped_mask_o;
  logic [BTN_W-1:0]       popped_button_o;
  logic                   popped_valid_o;
  logic [LEVEL_W-1:0]     queue_level_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = CFG_DEBOUNCE;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;

  button_debounce_cooldown_queue_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .now_ms_i         (now_ms_i),
    .raw_pressed_i    (raw_pressed_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .triggered_mask_o (triggered_mask_o),
    .dropped_mask_o   (dropped_mask_o),
    .popped_button_o  (popped_button_o),
    .popped_valid_o   (popped_valid_o),
    .queue_level_o    (queue_level_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [CFG_W-1:0]       debounce_ms = DEBOUNCE_RESET;
  logic [CFG_W-1:0]       cooldown_ms = COOLDOWN_RESET;
  logic [NUM_BUTTONS-1:0] raw_seen = '0;
  logic [NUM_BUTTONS-1:0] stable_seen = '0;
  logic [TIME_W-1:0]      change_time [NUM_BUTTONS];
  logic [TIME_W-1:0]      fire_time [NUM_BUTTONS];
  logic [BTN_W-1:0]       press_fifo [$];
  outcome_t               expected_outcomes [$];

  // stimulus state
  logic [TIME_W-1:0]      t_now = 32'd2000;
  logic [NUM_BUTTONS-1:0] held_raw = '0;
  bit                     gaps_on = 1'b1;
  int                     burst_left = 0;
  rx_mode_e               rx_mode = RX_ALWAYS;
  logic [3:0]             rx_phase = '0;
  logic                   hold_rx = 1'b0;
  int                     hold_cycles = 0;
  event                   hold_go;

  int n_errors = 0;
  int n_scans = 0;
  int n_pops = 0;
  int n_empty_pops = 0;
  int n_queued = 0;
  int n_dropped = 0;
  int n_results = 0;

  initial begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      change_time[b] = '0;
      fire_time[b] = '0;
    end
  end

  task automatic predict_button_events(input logic op, input logic [TIME_W-1:0] now,
                                       input logic [NUM_BUTTONS-1:0] raw);
    outcome_t          r;
    logic [TIME_W-1:0] held_for;
    logic [TIME_W-1:0] since_fire;
    r = '0;
    if (op == OP_SCAN) begin
      n_scans++;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (raw[b] != raw_seen[b]) begin
          raw_seen[b] = raw[b];
          change_time[b] = now;
        end
        held_for = now - change_time[b];
        if (held_for >= {16'd0, debounce_ms} && raw[b] != stable_seen[b]) begin
          stable_seen[b] = raw[b];
          since_fire = now - fire_time[b];
          if (raw[b] && since_fire >= {16'd0, cooldown_ms}) begin
            fire_time[b] = now;
            if (press_fifo.size() < QUEUE_DEPTH) begin
              press_fifo.push_back(BTN_W'(b));
              r.trig[b] = 1'b1;
            end else begin
              r.drop[b] = 1'b1;
            end
          end
        end
      end
      n_queued += $countones(r.trig);
      n_dropped += $countones(r.drop);
    end else begin
      n_pops++;
      if (press_fifo.size() != 0) begin
        r.btn = press_fifo.pop_front();
        r.pvalid = 1'b1;
      end else begin
        n_empty_pops++;
      end
    end
    r.level = LEVEL_W'(press_fifo.size());
    expected_outcomes.push_back(r);
  endtask

  // valid is left high on return so back-to-back transactions need no extra edge
  task automatic send_item(input logic op, input logic [TIME_W-1:0] now,
                           input logic [NUM_BUTTONS-1:0] raw);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    now_ms_i <= now;
    raw_pressed_i <= raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_button_events(op, now, raw);
  endtask

  task automatic pace();
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk_i);
        burst_left = $urandom_range(16, 1);
      end
      burst_left--;
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_DEBOUNCE) debounce_ms = val;
    else cooldown_ms = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] dbn, input logic [CFG_W-1:0] cool);
    wait_drain();
    write_register(CFG_DEBOUNCE, dbn);
    write_register(CFG_COOLDOWN, cool);
  endtask

  // press/release traffic: a sparse toggle on a few buttons per scan keeps
  // most presses held long enough to get through the debounce
  task automatic run_mixed(input int n, input int pop_pct, input int max_step,
                           input int flip_pct);
    gaps_on = ($urandom_range(3) != 0);
    rx_mode = rx_mode_e'($urandom_range(2));
    repeat (n) begin
      pace();
      if ($urandom_range(99) < pop_pct) begin
        send_item(OP_POP, $urandom, NUM_BUTTONS'($urandom));
      end else begin
        if ($urandom_range(99) < 2) t_now = $urandom;
        else t_now += $urandom_range(max_step);
        if ($urandom_range(99) < flip_pct)
          repeat ($urandom_range(3, 1)) held_raw[$urandom_range(NUM_BUTTONS-1)] ^= 1'b1;
        send_item(OP_SCAN, t_now, held_raw);
      end
    end
  endtask

  task automatic test_directed();
    send_item(OP_POP, '0, '0);                       // pop while empty
    send_item(OP_SCAN, 32'd1000, '1);
    send_item(OP_SCAN, 32'd1034, '1);                // one ms short of debounce
    send_item(OP_SCAN, 32'd1035, '1);                // all press: 8 queued, rest dropped
    repeat (QUEUE_DEPTH + 1) send_item(OP_POP, $urandom, NUM_BUTTONS'($urandom));
    send_item(OP_SCAN, 32'd1100, '0);
    send_item(OP_SCAN, 32'd1135, '0);
    send_item(OP_SCAN, 32'd1200, 24'h000001);
    send_item(OP_SCAN, 32'd1300, 24'h000001);        // stable again inside cooldown
    send_item(OP_SCAN, 32'd1400, '0);
    send_item(OP_SCAN, 32'd1500, '0);
    send_item(OP_SCAN, 32'd1834, 24'h800000);
    send_item(OP_SCAN, 32'd1840, '0);                // bounce, no press
    send_item(OP_SCAN, 32'd1900, '0);
    send_item(OP_SCAN, 32'd1950, 24'h800000);
    send_item(OP_SCAN, 32'd1985, 24'h800000);
    send_item(OP_POP, '1, '1);
    wait_drain();
  endtask

  task automatic test_default_timing();
    run_mixed(300, 35, 15, 25);
  endtask

  task automatic test_timing_sweep();
    set_timing(16'd0, 16'd0);
    run_mixed(130, 35, 20, 30);
    set_timing(16'hFFFF, 16'hFFFF);
    run_mixed(130, 30, 40000, 10);
    set_timing(16'hFFFF, 16'd0);
    run_mixed(130, 30, 40000, 10);
    set_timing(16'd0, 16'hFFFF);
    run_mixed(130, 30, 40000, 15);
    set_timing(16'd1, 16'd1);
    run_mixed(130, 35, 4, 30);
    repeat (2) begin
      set_timing(CFG_W'($urandom_range(60)), CFG_W'($urandom_range(400)));
      run_mixed(130, 35, 25, 30);
    end
  endtask

  task automatic test_queue_overflow();
    set_timing(16'd0, 16'd0);
    run_mixed(150, 6, 5, 70);
  endtask

  task automatic test_wrap();
    set_timing(16'd20, 16'd200);
    t_now = 32'hFFFF_FFFF - $urandom_range(1500);
    run_mixed(100, 30, 60, 30);
  endtask

  task automatic test_noise();
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    repeat (150) begin
      pace();
      send_item(logic'($urandom_range(1)), $urandom, NUM_BUTTONS'($urandom));
    end
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    set_timing(16'd5, 16'd30);
    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    hold_cycles = 400;
    -> hold_go;
    repeat (60) begin
      if ($urandom_range(99) < 30) send_item(OP_POP, $urandom, NUM_BUTTONS'($urandom));
      else begin
        t_now += $urandom_range(10);
        held_raw ^= NUM_BUTTONS'(1) << $urandom_range(NUM_BUTTONS-1);
        send_item(OP_SCAN, t_now, held_raw);
      end
    end
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_drain_pause();
    repeat (4) begin
      run_mixed(25, 35, 10, 30);
      wait_drain();
    end
  endtask

  // checker
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{triggered_mask_o, dropped_mask_o, popped_button_o, popped_valid_o,
              queue_level_o};
      n_results++;
      if (expected_outcomes.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: unexpected result trig=%h drop=%h btn=%0d pv=%b lvl=%0d",
                   $realtime, got.trig, got.drop, got.btn, got.pvalid, got.level);
      end else begin
        want = expected_outcomes.pop_front();
        if (got.trig !== want.trig || got.drop !== want.drop || got.btn !== want.btn ||
            got.pvalid !== want.pvalid || got.level !== want.level) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: mismatch trig %h/%h drop %h/%h btn %0d/%0d pv %b/%b lvl %0d/%0d",
                     $realtime, got.trig, want.trig, got.drop, want.drop, got.btn,
                     want.btn, got.pvalid, want.pvalid, got.level, want.level);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 4'd1;
    if (hold_rx) begin
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_RANDOM: out_ready_i <= ($urandom_range(99) < 65);
        default:   out_ready_i <= (rx_phase < 4'd11);
      endcase
    end
  end

  initial begin
    forever begin
      @(hold_go);
      hold_rx <= 1'b1;
      repeat (hold_cycles) @(posedge clk_i);
      hold_rx <= 1'b0;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_default_timing();
    test_timing_sweep();
    test_queue_overflow();
    test_wrap();
    test_noise();
    test_backpressure();
    test_drain_pause();
    wait_drain();
    repeat (40) @(posedge clk_i);
    $display("%0d transactions (%0d scans, %0d pops, %0d on an empty queue), %0d results",
             n_scans + n_pops, n_scans, n_pops, n_empty_pops, n_results);
    $display("%0d presses queued, %0d dropped on a full queue, %0d mismatches",
             n_queued, n_dropped, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_outcomes.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
